// ===== rtl/cou_pkg.sv =====
`timescale 1ns / 1ps
package cou_pkg;

    localparam int VEC_FRAC_BITS_DEF = 14;
    localparam int POS_BITS_DEF      = 32;

    localparam int FULL_TURN    = 230400;
    localparam int HALF_TURN    = 115200;
    localparam int QUARTER_TURN = 57600;

    localparam int CORDIC_STEPS     = 18;
    localparam int CORDIC_FRAC      = 30;
    localparam int CORDIC_GAIN_INIT = 652032874;
    localparam int CORDIC_CNT_W     = $clog2(CORDIC_STEPS);

    localparam int YAW_RESET = 172800;

    localparam logic [9:0]  LOOK_GAIN_RESET   = 10'd32;
    localparam logic [15:0] MOVE_GAIN_RESET   = 16'd512;
    localparam logic [15:0] PITCH_LIMIT_RESET = 16'd56960;

    localparam logic [1:0] CFG_LOOK_GAIN   = 2'd0;
    localparam logic [1:0] CFG_MOVE_GAIN   = 2'd1;
    localparam logic [1:0] CFG_PITCH_LIMIT = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOOK   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_ROTATE = 2'd2,
        CMD_PLACE  = 2'd3
    } t_command;

    typedef struct packed {
        logic       capture;
        logic       apply;
        logic       wrap;
        logic       cordic_start;
        logic       mul_en;
        logic       mul_scroll;
        logic [1:0] mul_idx;
        logic       pos_add;
        logic       vec_wr;
        logic [1:0] wr_idx;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_scroll;
        logic wrap_done;
        logic cordic_done;
    } t_dp_sts;

    // atan(2^-i) in 1/640 degree units, scaled by 256
    function automatic logic [22:0] cordic_atan(input logic [CORDIC_CNT_W-1:0] i);
        logic [22:0] v;
        unique case (i)
            5'd0:    v = 23'd7372800;
            5'd1:    v = 23'd4352418;
            5'd2:    v = 23'd2299698;
            5'd3:    v = 23'd1167363;
            5'd4:    v = 23'd585947;
            5'd5:    v = 23'd293259;
            5'd6:    v = 23'd146665;
            5'd7:    v = 23'd73337;
            5'd8:    v = 23'd36669;
            5'd9:    v = 23'd18335;
            5'd10:   v = 23'd9167;
            5'd11:   v = 23'd4584;
            5'd12:   v = 23'd2292;
            5'd13:   v = 23'd1146;
            5'd14:   v = 23'd573;
            5'd15:   v = 23'd286;
            5'd16:   v = 23'd143;
            5'd17:   v = 23'd72;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cou_cordic.sv =====
`timescale 1ns / 1ps
module cou_cordic #(
    parameter int VEC_FRAC_BITS = cou_pkg::VEC_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [18:0]             i_angle,
    output logic                           o_done,
    output logic signed [VEC_FRAC_BITS+1:0] o_sin,
    output logic signed [VEC_FRAC_BITS+1:0] o_cos
);
    import cou_pkg::*;

    localparam int VW = VEC_FRAC_BITS + 2;
    localparam int XW = 33;
    localparam int ZW = 27;
    localparam int SH = CORDIC_FRAC - VEC_FRAC_BITS;

    localparam logic signed [XW-1:0] RND  = XW'(1) << (SH - 1);
    localparam logic signed [XW-1:0] ONE  = XW'(1) << VEC_FRAC_BITS;
    localparam logic signed [XW-1:0] GAIN = XW'(CORDIC_GAIN_INIT);
    localparam logic signed [18:0] FULL_S    = 19'(FULL_TURN);
    localparam logic signed [18:0] HALF_S    = 19'(HALF_TURN);
    localparam logic signed [18:0] QUARTER_S = 19'(QUARTER_TURN);
    localparam logic [CORDIC_CNT_W-1:0] LAST = CORDIC_CNT_W'(CORDIC_STEPS - 1);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic [CORDIC_CNT_W-1:0] r_cnt;
    logic r_run, r_fin, r_done, r_neg;
    logic signed [VW-1:0] r_sin, r_cos;

    logic signed [18:0] a1, a2;
    logic fold_neg;
    logic signed [ZW-1:0] z0, at;
    logic signed [XW-1:0] sx, sy, xr, yr, xc, yc;
    logic signed [VW-1:0] fs, fc;

    // fold the angle into plus or minus a quarter turn
    always_comb begin
        a1 = (i_angle > HALF_S) ? i_angle - FULL_S : i_angle;
        fold_neg = 1'b0;
        a2 = a1;
        if (a1 > QUARTER_S) begin
            a2 = a1 - HALF_S;
            fold_neg = 1'b1;
        end else if (a1 < -QUARTER_S) begin
            a2 = a1 + HALF_S;
            fold_neg = 1'b1;
        end
        z0 = ZW'(a2) <<< 8;
    end

    always_comb begin
        sx = r_x >>> r_cnt;
        sy = r_y >>> r_cnt;
        at = $signed(ZW'(cordic_atan(r_cnt)));
        if (!r_z[ZW-1]) begin
            n_x = r_x - sy;
            n_y = r_y + sx;
            n_z = r_z - at;
        end else begin
            n_x = r_x + sy;
            n_y = r_y - sx;
            n_z = r_z + at;
        end
    end

    always_comb begin
        xr = (r_x + RND) >>> SH;
        yr = (r_y + RND) >>> SH;
        xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
        yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
        fc = r_neg ? -xc[VW-1:0] : xc[VW-1:0];
        fs = r_neg ? -yc[VW-1:0] : yc[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_cnt == LAST) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= GAIN;
            r_y   <= '0;
            r_z   <= z0;
            r_neg <= fold_neg;
            r_cnt <= '0;
        end else if (r_run) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= r_cnt + 1'b1;
        end else if (r_fin) begin
            r_sin <= fs;
            r_cos <= fc;
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_sin;
    assign o_cos  = r_cos;

endmodule

// ===== rtl/cou_datapath.sv =====
`timescale 1ns / 1ps
module cou_datapath #(
    parameter int VEC_FRAC_BITS = cou_pkg::VEC_FRAC_BITS_DEF,
    parameter int POS_BITS      = cou_pkg::POS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cou_pkg::t_dp_cmd                i_cmd,
    output cou_pkg::t_dp_sts                o_sts,
    input  logic                            i_cfg_we,
    input  logic [1:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic [1:0]                      i_command,
    input  logic signed [11:0]              i_look_dx,
    input  logic signed [11:0]              i_look_dy,
    input  logic signed [5:0]               i_scroll_steps,
    input  logic [17:0]                     i_new_yaw,
    input  logic signed [16:0]              i_new_pitch,
    input  logic signed [31:0]              i_new_pos_x,
    input  logic signed [31:0]              i_new_pos_y,
    input  logic signed [31:0]              i_new_pos_z,
    output logic [17:0]                     o_yaw_out,
    output logic signed [16:0]              o_pitch_out,
    output logic signed [VEC_FRAC_BITS+1:0] o_fwd_x,
    output logic signed [VEC_FRAC_BITS+1:0] o_fwd_y,
    output logic signed [VEC_FRAC_BITS+1:0] o_fwd_z,
    output logic signed [VEC_FRAC_BITS+1:0] o_up_x,
    output logic signed [VEC_FRAC_BITS+1:0] o_up_y,
    output logic signed [VEC_FRAC_BITS+1:0] o_up_z,
    output logic signed [POS_BITS-1:0]      o_pos_x_out,
    output logic signed [POS_BITS-1:0]      o_pos_y_out,
    output logic signed [POS_BITS-1:0]      o_pos_z_out
);
    import cou_pkg::*;

    localparam int VW  = VEC_FRAC_BITS + 2;
    localparam int AW  = 23;
    localparam int PRW = AW + VW;
    localparam int SW  = ((POS_BITS > PRW) ? POS_BITS : PRW) + 1;

    localparam logic signed [22:0] FULL_S    = 23'(FULL_TURN);
    localparam logic [15:0]        QUARTER_U = 16'(QUARTER_TURN);
    localparam logic signed [VW-1:0]  VONE = VW'(1) << VEC_FRAC_BITS;
    localparam logic signed [PRW-1:0] PRND = PRW'(1) << (VEC_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] PMAX = {{(SW-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] PMIN = ~PMAX;

    logic [9:0]  r_look_gain;
    logic [15:0] r_move_gain, r_pitch_limit;

    logic [1:0]           r_cmd;
    logic [17:0]          r_new_yaw;
    logic signed [16:0]   r_new_pitch;
    logic signed [31:0]   r_new_pos [3];
    logic signed [22:0]   r_dx_prod, r_dy_prod, r_sg;

    logic signed [22:0]         r_yaw;
    logic signed [16:0]         r_pitch;
    logic signed [POS_BITS-1:0] r_pos [3];
    logic signed [VW-1:0]       r_fwd [3];
    logic signed [VW-1:0]       r_up  [3];
    logic signed [PRW-1:0]      r_prod;

    logic [17:0]                r_o_yaw;
    logic signed [16:0]         r_o_pitch;
    logic signed [VW-1:0]       r_o_fwd [3];
    logic signed [VW-1:0]       r_o_up  [3];
    logic signed [POS_BITS-1:0] r_o_pos [3];

    logic yaw_done, pitch_done;
    logic signed [VW-1:0] sy, cy, sp, cp;

    logic signed [22:0]     lim, pitch_sum, pitch_src, pitch_clamped;
    logic signed [AW-1:0]   mul_a;
    logic signed [VW-1:0]   mul_b, fwd_sel, vterm;
    logic signed [PRW-1:0]  rd;
    logic signed [POS_BITS-1:0] pos_sel, pos_sum_sat;
    logic signed [SW-1:0]   pos_sum;
    logic signed [POS_BITS-1:0] place_sat [3];

    cou_cordic #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cordic_start),
        .i_angle (r_yaw[18:0]),
        .o_done  (yaw_done),
        .o_sin   (sy),
        .o_cos   (cy)
    );

    cou_cordic #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cordic_start),
        .i_angle (19'(r_pitch)),
        .o_done  (pitch_done),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    assign o_sts.is_scroll   = (r_cmd == CMD_SCROLL);
    assign o_sts.wrap_done   = !r_yaw[22] && (r_yaw < FULL_S);
    assign o_sts.cordic_done = yaw_done && pitch_done;

    // pitch clamp against the limit, capped at ninety degrees
    always_comb begin
        lim = $signed(23'((r_pitch_limit > QUARTER_U) ? QUARTER_U : r_pitch_limit));
        pitch_sum = 23'(r_pitch) + r_dy_prod;
        pitch_src = (r_cmd == CMD_LOOK) ? pitch_sum : 23'(r_new_pitch);
        if (pitch_src > lim) begin
            pitch_clamped = lim;
        end else if (pitch_src < -lim) begin
            pitch_clamped = -lim;
        end else begin
            pitch_clamped = pitch_src;
        end
    end

    always_comb begin
        unique case (i_cmd.mul_idx)
            2'd0:    fwd_sel = r_fwd[0];
            2'd1:    fwd_sel = r_fwd[1];
            default: fwd_sel = r_fwd[2];
        endcase
        if (i_cmd.mul_scroll) begin
            mul_a = r_sg;
            mul_b = fwd_sel;
        end else begin
            mul_a = AW'(i_cmd.mul_idx[0] ? sy : cy);
            mul_b = i_cmd.mul_idx[1] ? sp : cp;
        end
    end

    always_comb begin
        rd = (r_prod + PRND) >>> VEC_FRAC_BITS;
        vterm = i_cmd.wr_idx[1] ? -rd[VW-1:0] : rd[VW-1:0];
        unique case (i_cmd.wr_idx)
            2'd0:    pos_sel = r_pos[0];
            2'd1:    pos_sel = r_pos[1];
            default: pos_sel = r_pos[2];
        endcase
        pos_sum = SW'(pos_sel) + SW'(rd);
        if (pos_sum > PMAX) begin
            pos_sum_sat = PMAX[POS_BITS-1:0];
        end else if (pos_sum < PMIN) begin
            pos_sum_sat = PMIN[POS_BITS-1:0];
        end else begin
            pos_sum_sat = pos_sum[POS_BITS-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (SW'(r_new_pos[k]) > PMAX) begin
                place_sat[k] = PMAX[POS_BITS-1:0];
            end else if (SW'(r_new_pos[k]) < PMIN) begin
                place_sat[k] = PMIN[POS_BITS-1:0];
            end else begin
                place_sat[k] = POS_BITS'(r_new_pos[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look_gain   <= LOOK_GAIN_RESET;
            r_move_gain   <= MOVE_GAIN_RESET;
            r_pitch_limit <= PITCH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LOOK_GAIN) begin
                r_look_gain <= i_cfg_data[9:0];
            end else if (i_cfg_index == CFG_MOVE_GAIN) begin
                r_move_gain <= i_cfg_data;
            end else if (i_cfg_index == CFG_PITCH_LIMIT) begin
                r_pitch_limit <= i_cfg_data;
            end
        end
    end

    // latch the request and its gain products; register the multiplier product
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd        <= i_command;
            r_new_yaw    <= i_new_yaw;
            r_new_pitch  <= i_new_pitch;
            r_new_pos[0] <= i_new_pos_x;
            r_new_pos[1] <= i_new_pos_y;
            r_new_pos[2] <= i_new_pos_z;
            r_dx_prod    <= i_look_dx * $signed({1'b0, r_look_gain});
            r_dy_prod    <= i_look_dy * $signed({1'b0, r_look_gain});
            r_sg         <= i_scroll_steps * $signed({1'b0, r_move_gain});
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= 23'(YAW_RESET);
            r_pitch <= '0;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
            end
            r_fwd[0] <= '0;
            r_fwd[1] <= '0;
            r_fwd[2] <= -VONE;
            r_up[0]  <= '0;
            r_up[1]  <= VONE;
            r_up[2]  <= '0;
        end else begin
            if (i_cmd.apply) begin
                if (r_cmd == CMD_LOOK) begin
                    r_yaw   <= r_yaw + r_dx_prod;
                    r_pitch <= pitch_clamped[16:0];
                end else if (r_cmd == CMD_ROTATE) begin
                    r_yaw   <= 23'(r_new_yaw);
                    r_pitch <= pitch_clamped[16:0];
                end else if (r_cmd == CMD_PLACE) begin
                    for (int k = 0; k < 3; k++) begin
                        r_pos[k] <= place_sat[k];
                    end
                end
            end
            if (i_cmd.wrap) begin
                if (r_yaw[22]) begin
                    r_yaw <= r_yaw + FULL_S;
                end else if (r_yaw >= FULL_S) begin
                    r_yaw <= r_yaw - FULL_S;
                end
            end
            if (i_cmd.pos_add) begin
                unique case (i_cmd.wr_idx)
                    2'd0:    r_pos[0] <= pos_sum_sat;
                    2'd1:    r_pos[1] <= pos_sum_sat;
                    default: r_pos[2] <= pos_sum_sat;
                endcase
            end
            if (i_cmd.vec_wr) begin
                r_fwd[1] <= sp;
                r_up[1]  <= cp;
                unique case (i_cmd.wr_idx)
                    2'd0:    r_fwd[0] <= vterm;
                    2'd1:    r_fwd[2] <= vterm;
                    2'd2:    r_up[0]  <= vterm;
                    default: r_up[2]  <= vterm;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_yaw   <= r_yaw[17:0];
            r_o_pitch <= r_pitch;
            for (int k = 0; k < 3; k++) begin
                r_o_fwd[k] <= r_fwd[k];
                r_o_up[k]  <= r_up[k];
                r_o_pos[k] <= r_pos[k];
            end
        end
    end

    assign o_yaw_out   = r_o_yaw;
    assign o_pitch_out = r_o_pitch;
    assign o_fwd_x     = r_o_fwd[0];
    assign o_fwd_y     = r_o_fwd[1];
    assign o_fwd_z     = r_o_fwd[2];
    assign o_up_x      = r_o_up[0];
    assign o_up_y      = r_o_up[1];
    assign o_up_z      = r_o_up[2];
    assign o_pos_x_out = r_o_pos[0];
    assign o_pos_y_out = r_o_pos[1];
    assign o_pos_z_out = r_o_pos[2];

endmodule

// ===== rtl/cou_ctrl.sv =====
`timescale 1ns / 1ps
module cou_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output cou_pkg::t_dp_cmd o_cmd,
    input  cou_pkg::t_dp_sts i_sts
);
    import cou_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_APPLY  = 8'b0000_0010,
        S_SMUL   = 8'b0000_0100,
        S_SADD   = 8'b0000_1000,
        S_WRAP   = 8'b0001_0000,
        S_CORDIC = 8'b0010_0000,
        S_VEC    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic [2:0] cnt_m1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign cnt_m1      = r_cnt - 3'd1;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_cnt = '0;
                n_state = i_sts.is_scroll ? S_SMUL : S_WRAP;
            end
            S_SMUL: begin
                o_cmd.mul_en     = 1'b1;
                o_cmd.mul_scroll = 1'b1;
                o_cmd.mul_idx    = r_cnt[1:0];
                n_state = S_SADD;
            end
            S_SADD: begin
                o_cmd.pos_add = 1'b1;
                o_cmd.wr_idx  = r_cnt[1:0];
                n_cnt = r_cnt + 3'd1;
                n_state = (r_cnt == 3'd2) ? S_WRAP : S_SMUL;
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                if (i_sts.wrap_done) begin
                    o_cmd.cordic_start = 1'b1;
                    n_state = S_CORDIC;
                end
            end
            S_CORDIC: begin
                n_cnt = '0;
                if (i_sts.cordic_done) begin
                    n_state = S_VEC;
                end
            end
            S_VEC: begin
                // multiply term k while writing back term k-1
                o_cmd.mul_en  = (r_cnt != 3'd4);
                o_cmd.mul_idx = r_cnt[1:0];
                o_cmd.vec_wr  = (r_cnt != 3'd0);
                o_cmd.wr_idx  = cnt_m1[1:0];
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/camera_orientation_update.sv =====
`timescale 1ns / 1ps
// First-person camera state: yaw, pitch and position, updated by one request
// at a time (mouse look, scroll, set rotation, set position). Each request
// yields one result with the angles, unit forward and up vectors and the
// position. Yaw is brought back into range one full turn at a time: up to 10
// turns after a large mouse move, one for a set yaw of a full turn or more.
// The two 18-step CORDIC units run side by side, one for yaw and one for
// pitch. One shared multiplier forms the scroll products and then the vector
// products. A new request is taken the cycle after the previous one has been
// handed to the output register, and not before. A result still waiting in
// that register holds the block until it is taken.
module camera_orientation_update #(
    parameter int VEC_FRAC_BITS = cou_pkg::VEC_FRAC_BITS_DEF,
    parameter int POS_BITS      = cou_pkg::POS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [1:0]                      i_cfg_index,
    input  logic [15:0]                     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_command,
    input  logic signed [11:0]              i_look_dx,
    input  logic signed [11:0]              i_look_dy,
    input  logic signed [5:0]               i_scroll_steps,
    input  logic [17:0]                     i_new_yaw,
    input  logic signed [16:0]              i_new_pitch,
    input  logic signed [31:0]              i_new_pos_x,
    input  logic signed [31:0]              i_new_pos_y,
    input  logic signed [31:0]              i_new_pos_z,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [17:0]                     o_yaw_out,
    output logic signed [16:0]              o_pitch_out,
    output logic signed [VEC_FRAC_BITS+1:0] o_fwd_x,
    output logic signed [VEC_FRAC_BITS+1:0] o_fwd_y,
    output logic signed [VEC_FRAC_BITS+1:0] o_fwd_z,
    output logic signed [VEC_FRAC_BITS+1:0] o_up_x,
    output logic signed [VEC_FRAC_BITS+1:0] o_up_y,
    output logic signed [VEC_FRAC_BITS+1:0] o_up_z,
    output logic signed [POS_BITS-1:0]      o_pos_x_out,
    output logic signed [POS_BITS-1:0]      o_pos_y_out,
    output logic signed [POS_BITS-1:0]      o_pos_z_out
);
    import cou_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    cou_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    cou_datapath #(
        .VEC_FRAC_BITS (VEC_FRAC_BITS),
        .POS_BITS      (POS_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_look_dx      (i_look_dx),
        .i_look_dy      (i_look_dy),
        .i_scroll_steps (i_scroll_steps),
        .i_new_yaw      (i_new_yaw),
        .i_new_pitch    (i_new_pitch),
        .i_new_pos_x    (i_new_pos_x),
        .i_new_pos_y    (i_new_pos_y),
        .i_new_pos_z    (i_new_pos_z),
        .o_yaw_out      (o_yaw_out),
        .o_pitch_out    (o_pitch_out),
        .o_fwd_x        (o_fwd_x),
        .o_fwd_y        (o_fwd_y),
        .o_fwd_z        (o_fwd_z),
        .o_up_x         (o_up_x),
        .o_up_y         (o_up_y),
        .o_up_z         (o_up_z),
        .o_pos_x_out    (o_pos_x_out),
        .o_pos_y_out    (o_pos_y_out),
        .o_pos_z_out    (o_pos_z_out)
    );

endmodule

// ===== dv/camera_orientation_update_tb.sv =====
`timescale 1ns / 1ps
module camera_orientation_update_tb;
    import cou_pkg::*;

    localparam int VFB = 14;
    localparam int PB  = 32;
    localparam longint LIMIT_CYCLES = 600000;

    typedef struct {
        logic [1:0]         command;
        logic signed [11:0] dx;
        logic signed [11:0] dy;
        logic signed [5:0]  steps;
        logic [17:0]        yaw;
        logic signed [16:0] pitch;
        logic signed [31:0] px, py, pz;
    } t_req;

    typedef struct {
        logic [17:0]        yaw;
        logic signed [16:0] pitch;
        logic signed [15:0] fwd[3];
        logic signed [15:0] up[3];
        logic signed [31:0] pos[3];
    } t_view;

    int errors = 0;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("error: %s got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return asr(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_turn(longint a);
        longint r;
        r = a % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        return r;
    endfunction

    class camera_scoreboard;
        longint look_gain, move_gain, pitch_limit;
        longint yaw, pitch;
        longint pos[3], fwd[3], up[3];
        t_view pending[$];
        longint atan_steps[18] = '{7372800, 4352418, 2299698, 1167363, 585947, 293259,
            146665, 73337, 36669, 18335, 9167, 4584, 2292, 1146, 573, 286, 143, 72};

        function void clear();
            look_gain = LOOK_GAIN_RESET; move_gain = MOVE_GAIN_RESET;
            pitch_limit = PITCH_LIMIT_RESET;
            yaw = YAW_RESET; pitch = 0;
            pos = '{0, 0, 0}; fwd = '{0, 0, -(1 << VFB)}; up = '{0, 1 << VFB, 0};
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == CFG_LOOK_GAIN) look_gain = val[9:0];
            else if (idx == CFG_MOVE_GAIN) move_gain = val;
            else if (idx == CFG_PITCH_LIMIT) pitch_limit = val;
        endfunction

        function void rotate(longint a, output longint s, output longint c);
            longint x, y, z, xn, one;
            bit flip;
            one = 1 << VFB; x = CORDIC_GAIN_INIT; y = 0; flip = 0;
            a = wrap_turn(a);
            if (a > HALF_TURN) a -= FULL_TURN;
            if (a > QUARTER_TURN) begin a -= HALF_TURN; flip = 1; end
            else if (a < -QUARTER_TURN) begin a += HALF_TURN; flip = 1; end
            z = a * 256;
            for (int i = 0; i < 18; i++) begin
                if (z >= 0) begin
                    xn = x - asr(y, i); y = y + asr(x, i); z -= atan_steps[i];
                end else begin
                    xn = x + asr(y, i); y = y - asr(x, i); z += atan_steps[i];
                end
                x = xn;
            end
            x = clip(round_shift(x, CORDIC_FRAC - VFB), -one, one);
            y = clip(round_shift(y, CORDIC_FRAC - VFB), -one, one);
            if (flip) begin x = -x; y = -y; end
            s = y; c = x;
        endfunction

        function void note_request(t_req r);
            longint lim, sy, cy, sp, cp, hi;
            t_view v;
            lim = pitch_limit > QUARTER_TURN ? QUARTER_TURN : pitch_limit;
            hi = (longint'(1) << (PB - 1)) - 1;
            case (t_command'(r.command))
                CMD_LOOK: begin
                    yaw = wrap_turn(yaw + longint'(r.dx) * look_gain);
                    pitch = clip(pitch + longint'(r.dy) * look_gain, -lim, lim);
                end
                CMD_SCROLL: begin
                    if (r.steps != 0)
                        for (int i = 0; i < 3; i++)
                            pos[i] = clip(pos[i] + round_shift(longint'(r.steps)
                                * move_gain * fwd[i], VFB), -hi - 1, hi);
                end
                CMD_ROTATE: begin
                    yaw = wrap_turn(longint'(r.yaw));
                    pitch = clip(longint'(r.pitch), -lim, lim);
                end
                default: begin
                    pos[0] = r.px; pos[1] = r.py; pos[2] = r.pz;
                end
            endcase
            rotate(yaw, sy, cy);
            rotate(pitch, sp, cp);
            fwd[0] = round_shift(cy * cp, VFB); fwd[1] = sp;
            fwd[2] = round_shift(sy * cp, VFB);
            up[0] = -round_shift(cy * sp, VFB); up[1] = cp;
            up[2] = -round_shift(sy * sp, VFB);
            v.yaw = 18'(yaw); v.pitch = 17'(pitch);
            for (int i = 0; i < 3; i++) begin
                v.fwd[i] = 16'(fwd[i]); v.up[i] = 16'(up[i]); v.pos[i] = 32'(pos[i]);
            end
            pending = {pending, v};
        endfunction

        task check_result(t_view g);
            t_view w;
            if (pending.size() == 0) begin
                report("unexpected result yaw", g.yaw, -1);
                return;
            end
            w = pending.pop_front();
            if (g.yaw !== w.yaw) report("yaw", g.yaw, w.yaw);
            if (g.pitch !== w.pitch) report("pitch", g.pitch, w.pitch);
            for (int i = 0; i < 3; i++) begin
                if (g.fwd[i] !== w.fwd[i]) report($sformatf("fwd[%0d]", i), g.fwd[i], w.fwd[i]);
                if (g.up[i] !== w.up[i]) report($sformatf("up[%0d]", i), g.up[i], w.up[i]);
                if (g.pos[i] !== w.pos[i]) report($sformatf("pos[%0d]", i), g.pos[i], w.pos[i]);
            end
        endtask
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_valid = 0, o_cfg_ready;
    logic [1:0] i_cfg_index = 0;
    logic [15:0] i_cfg_data = 0;
    logic i_in_valid = 0, o_in_ready;
    logic [1:0] i_command = 0;
    logic signed [11:0] i_look_dx = 0, i_look_dy = 0;
    logic signed [5:0] i_scroll_steps = 0;
    logic [17:0] i_new_yaw = 0;
    logic signed [16:0] i_new_pitch = 0;
    logic signed [31:0] i_new_pos_x = 0, i_new_pos_y = 0, i_new_pos_z = 0;
    logic o_out_valid, i_out_ready = 0;
    logic [17:0] o_yaw_out;
    logic signed [16:0] o_pitch_out;
    logic signed [15:0] o_fwd_x, o_fwd_y, o_fwd_z, o_up_x, o_up_y, o_up_z;
    logic signed [31:0] o_pos_x_out, o_pos_y_out, o_pos_z_out;

    camera_orientation_update uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    camera_scoreboard camera_sb = new();
    int send_idle_pct = 0, recv_stall_pct = 0;
    int hold_off = 0;
    longint cycles = 0;

    // receiver: sample at the rising edge, change ready at the falling one
    always @(posedge i_clk) begin
        t_view g;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            g.yaw = o_yaw_out; g.pitch = o_pitch_out;
            g.fwd = '{o_fwd_x, o_fwd_y, o_fwd_z};
            g.up = '{o_up_x, o_up_y, o_up_z};
            g.pos = '{o_pos_x_out, o_pos_y_out, o_pos_z_out};
            camera_sb.check_result(g);
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        camera_sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_request(input t_req r);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid <= 1; i_command <= r.command; i_look_dx <= r.dx; i_look_dy <= r.dy;
        i_scroll_steps <= r.steps; i_new_yaw <= r.yaw; i_new_pitch <= r.pitch;
        i_new_pos_x <= r.px; i_new_pos_y <= r.py; i_new_pos_z <= r.pz;
        do @(posedge i_clk); while (!o_in_ready);
        camera_sb.note_request(r);
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    task automatic drain();
        while (camera_sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic t_req make_req(logic [1:0] c);
        t_req r;
        r.command = c;
        r.dx = 12'($urandom); r.dy = 12'($urandom); r.steps = 6'($urandom);
        r.yaw = 18'($urandom_range(FULL_TURN - 1));
        r.pitch = 17'($urandom_range(113920) - 56960);
        r.px = $urandom; r.py = $urandom; r.pz = $urandom;
        if ($urandom_range(9) == 0) r.steps = 6'($urandom_range(32) - 16);
        if ($urandom_range(9) == 0) r.dx = 12'($urandom_range(20) - 10);
        if ($urandom_range(9) == 0) r.dy = 12'($urandom_range(20) - 10);
        if ($urandom_range(19) == 0) r.yaw = 18'($urandom);
        if ($urandom_range(19) == 0) r.pitch = 17'($urandom);
        if ($urandom_range(3) == 0) begin
            r.px = $signed(r.px) >>> 12; r.py = $signed(r.py) >>> 12;
            r.pz = $signed(r.pz) >>> 12;
        end
        return r;
    endfunction

    function automatic t_req direct(logic [1:0] c, int a, int b, int s,
                                    int y, int p, int q);
        t_req r;
        r = make_req(c);
        r.dx = 12'(a); r.dy = 12'(b); r.steps = 6'(s); r.yaw = 18'(y); r.pitch = 17'(p);
        r.px = q; r.py = -q - 1; r.pz = q;
        return r;
    endfunction

    initial begin
        int phase_pct[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{31, 31}};
        logic [15:0] look_set[4] = '{16'd1023, 16'd0, 16'd7, 16'd32};
        logic [15:0] move_set[4] = '{16'd65535, 16'd0, 16'd300, 16'd512};
        logic [15:0] limit_set[4] = '{16'd65535, 16'd0, 16'd57600, 16'd56960};
        camera_sb.clear();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed corners: extremes, wrap, clamp, vertical view, saturation
        send_request(direct(CMD_LOOK, 0, 0, 0, 0, 0, 0));
        send_request(direct(CMD_LOOK, 2047, 2047, 0, 0, 0, 0));
        send_request(direct(CMD_LOOK, -2048, -2048, 0, 0, 0, 0));
        send_request(direct(CMD_SCROLL, 0, 0, 0, 0, 0, 0));
        send_request(direct(CMD_SCROLL, 0, 0, 16, 0, 0, 0));
        send_request(direct(CMD_SCROLL, 0, 0, -32, 0, 0, 0));
        send_request(direct(CMD_SCROLL, 0, 0, 31, 0, 0, 0));
        send_request(direct(CMD_ROTATE, 0, 0, 0, 230399, 56960, 0));
        send_request(direct(CMD_ROTATE, 0, 0, 0, 262143, -65536, 0));
        send_request(direct(CMD_ROTATE, 0, 0, 0, 230400, 65535, 0));
        send_request(direct(CMD_PLACE, 0, 0, 0, 0, 0, 32'h7fffffff));
        send_request(direct(CMD_SCROLL, 0, 0, 16, 0, 0, 0));
        send_request(direct(CMD_PLACE, 0, 0, 0, 0, 0, 32'h80000000));
        send_request(direct(CMD_SCROLL, 0, 0, -16, 0, 0, 0));
        drain();
        write_reg(CFG_PITCH_LIMIT, 16'hffff);
        write_reg(CFG_MOVE_GAIN, 16'hffff);
        write_reg(CFG_LOOK_GAIN, 16'd1023);
        send_request(direct(CMD_ROTATE, 0, 0, 0, 57600, 57600, 0));
        send_request(direct(CMD_ROTATE, 0, 0, 0, 115200, -57600, 0));
        send_request(direct(CMD_LOOK, 0, 2047, 0, 0, 0, 0));
        send_request(direct(CMD_LOOK, 0, -2048, 0, 0, 0, 0));
        send_request(direct(CMD_SCROLL, 0, 0, 16, 0, 0, 0));
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_LOOK_GAIN, look_set[ph]);
            write_reg(CFG_MOVE_GAIN, move_set[ph]);
            write_reg(CFG_PITCH_LIMIT, limit_set[ph]);
            for (int k = 0; k < 4; k++) begin
                send_idle_pct = phase_pct[k][0];
                recv_stall_pct = phase_pct[k][1];
                if (ph == 1 && k == 0) hold_off = 400;
                // also a quiet stretch with neither side idling, but for the hold-off when ph is 1
                for (int n = 0; n < 65; n++) send_request(make_req(2'($urandom_range(3))));
            end
            send_idle_pct = 0; recv_stall_pct = 0;
            drain();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/cou_pkg.sv
rtl/cou_cordic.sv
rtl/cou_datapath.sv
rtl/cou_ctrl.sv
rtl/camera_orientation_update.sv
dv/camera_orientation_update_tb.sv
